/* rtl/core/pbfr_pkg.sv */
// Shared types, constants and register indexes for the background fetch and render unit.
package pbfr_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TILE_PIXELS     = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PT_HIGH   = 2'd2;

  localparam logic [2:0] PH_NAME_REQ = 3'd0;
  localparam logic [2:0] PH_NAME_DAT = 3'd1;
  localparam logic [2:0] PH_ATTR_REQ = 3'd2;
  localparam logic [2:0] PH_ATTR_DAT = 3'd3;
  localparam logic [2:0] PH_LOW_REQ  = 3'd4;
  localparam logic [2:0] PH_LOW_DAT  = 3'd5;
  localparam logic [2:0] PH_HIGH_REQ = 3'd6;
  localparam logic [2:0] PH_HIGH_DAT = 3'd7;

  typedef struct packed {
    logic [8:0] dot_index;
    logic       prerender_line;
    logic [7:0] read_data;
  } pbfr_in_t;

  typedef struct packed {
    logic        pixel_visible;
    logic [1:0]  palette_select;
    logic [1:0]  color_index;
    logic        read_request;
    logic [13:0] read_address;
  } pbfr_out_t;

  typedef struct packed {
    logic        shift;
    logic        load;
    logic        visible;
    logic [1:0]  attr;
    logic [7:0]  pat_lo;
    logic [7:0]  pat_hi;
    logic        req;
    logic [13:0] addr;
  } pbfr_ctl_t;

endpackage

/* rtl/core/pbfr_queue_cell.sv */
// One entry of the pixel shift queue: takes its right neighbour or a tile pixel.
module pbfr_queue_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       load_en,
  input  logic [3:0] load_val,
  input  logic [3:0] shift_in,
  output logic [3:0] q
);

  logic [3:0] q_r;
  logic [3:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = load_en ? load_val : shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/pbfr_fetch.sv */
// Scroll address, tile fetch sequencing and video memory request generation.
module pbfr_fetch (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  pbfr_pkg::pbfr_in_t               in_item,
  input  logic                             cfg_we,
  input  logic [pbfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pbfr_pkg::pbfr_ctl_t              ctl
);
  import pbfr_pkg::*;

  logic [14:0] temp_addr_r;
  logic        pt_high_r;
  logic [14:0] v_r, v_nxt;
  logic [7:0]  name_r, name_nxt;
  logic [1:0]  attr_r, attr_nxt;
  logic [7:0]  pat_lo_r, pat_lo_nxt;
  logic [13:0] pat_addr_r, pat_addr_nxt;

  logic [8:0]  dot;
  logic        active;
  logic [2:0]  phase;
  logic [8:0]  dot_m1;
  logic [13:0] low_addr;

  localparam logic [14:0] HORIZ_BITS = 15'h041F;
  localparam logic [14:0] VERT_BITS  = 15'h7BE0;

  function automatic logic [14:0] step_x(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[4:0] == 5'd31) begin
      r[4:0] = '0;
      r[10]  = ~v[10];
    end else begin
      r[4:0] = v[4:0] + 5'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] step_y(input logic [14:0] v);
    logic [14:0] r;
    logic [2:0]  fy;
    logic [4:0]  cy;
    r  = v;
    fy = v[14:12];
    cy = v[9:5];
    if (fy != 3'd7) begin
      fy = fy + 3'd1;
    end else begin
      fy = '0;
      if (cy == 5'd29) begin
        cy    = '0;
        r[11] = ~v[11];
      end else if (cy == 5'd31) begin
        cy = '0;
      end else begin
        cy = cy + 5'd1;
      end
    end
    r[14:12] = fy;
    r[9:5]   = cy;
    return r;
  endfunction

  assign dot      = in_item.dot_index;
  assign active   = ((dot >= 9'd1) && (dot <= 9'd256)) || ((dot >= 9'd321) && (dot <= 9'd336));
  assign dot_m1   = dot - 9'd1;
  assign phase    = dot_m1[2:0];
  assign low_addr = {1'b0, pt_high_r, name_r, 1'b0, v_r[14:12]};

  always_comb begin
    v_nxt        = v_r;
    name_nxt     = name_r;
    attr_nxt     = attr_r;
    pat_lo_nxt   = pat_lo_r;
    pat_addr_nxt = pat_addr_r;
    ctl          = '0;
    ctl.shift    = active;
    ctl.visible  = active && !in_item.prerender_line && (dot <= 9'd256);
    ctl.attr     = attr_r;
    ctl.pat_lo   = pat_lo_r;
    ctl.pat_hi   = in_item.read_data;
    if (active) begin
      case (phase)
        PH_NAME_REQ: begin
          ctl.req  = 1'b1;
          ctl.addr = {2'b10, v_r[11:0]};
        end
        PH_NAME_DAT: begin
          name_nxt = in_item.read_data;
        end
        PH_ATTR_REQ: begin
          ctl.req  = 1'b1;
          ctl.addr = {2'b10, v_r[11:10], 4'b1111, v_r[9:7], v_r[4:2]};
        end
        PH_ATTR_DAT: begin
          case ({v_r[6], v_r[1]})
            2'b00:   attr_nxt = in_item.read_data[1:0];
            2'b01:   attr_nxt = in_item.read_data[3:2];
            2'b10:   attr_nxt = in_item.read_data[5:4];
            default: attr_nxt = in_item.read_data[7:6];
          endcase
        end
        PH_LOW_REQ: begin
          pat_addr_nxt = low_addr;
          ctl.req      = 1'b1;
          ctl.addr     = low_addr;
        end
        PH_LOW_DAT: begin
          pat_lo_nxt = in_item.read_data;
        end
        PH_HIGH_REQ: begin
          pat_addr_nxt = pat_addr_r + 14'd8;
          ctl.req      = 1'b1;
          ctl.addr     = pat_addr_nxt;
        end
        default: begin
          ctl.load = 1'b1;
          v_nxt    = step_x(v_r);
        end
      endcase
      if (dot == 9'd256) begin
        v_nxt = step_y(v_nxt);
      end
    end else if (dot == 9'd257) begin
      v_nxt = (v_r & ~HORIZ_BITS) | (temp_addr_r & HORIZ_BITS);
    end else if ((dot >= 9'd280) && (dot <= 9'd304) && in_item.prerender_line) begin
      v_nxt = (v_r & ~VERT_BITS) | (temp_addr_r & VERT_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_addr_r <= '0;
      pt_high_r   <= 1'b0;
      v_r         <= '0;
      name_r      <= '0;
      attr_r      <= '0;
      pat_lo_r    <= '0;
      pat_addr_r  <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_TEMP_ADDR)) begin
        temp_addr_r <= cfg_data[14:0];
      end
      if (cfg_we && (cfg_index == CFG_PT_HIGH)) begin
        pt_high_r <= cfg_data[0];
      end
      if (step) begin
        v_r        <= v_nxt;
        name_r     <= name_nxt;
        attr_r     <= attr_nxt;
        pat_lo_r   <= pat_lo_nxt;
        pat_addr_r <= pat_addr_nxt;
      end
    end
  end

endmodule

/* rtl/core/ppu_background_fetch_render_unit.sv */
// Top level of the background fetch and render unit: queue cells, fetch logic, result register.
//
//  channel | ports                                   | direction
//  input   | in_valid, in_ready, in_data             | one dot per request
//  result  | out_valid, out_ready, out_data          | one result per dot
//  config  | cfg_we, cfg_index, cfg_data             | write only, no wait
//
// One dot per cycle while results drain; each result appears the cycle after its dot is taken.
// The whole step (queue shift, fetch, scroll update) is done in the cycle of acceptance.
// The result register frees in_ready whenever it is empty or being taken.
// Synchronous active-low reset clears scroll, fetch registers, queue and config.
module ppu_background_fetch_render_unit #(
  parameter int unsigned QUEUE_DEPTH = pbfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pbfr_pkg::pbfr_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pbfr_pkg::pbfr_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [pbfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pbfr_pkg::*;

  localparam int unsigned QW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned FIRST = QUEUE_DEPTH - TILE_PIXELS;

  logic        accept;
  pbfr_ctl_t   ctl;
  logic [3:0]  queue [QUEUE_DEPTH];
  logic [3:0]  entry;
  logic [2:0]  fine_x_r;
  logic        out_valid_r;
  pbfr_out_t   out_data_r, out_data_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  pbfr_fetch u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [3:0] load_val;
    logic       load_en;
    logic [3:0] shift_in;
    if (i >= FIRST) begin : g_tail
      localparam int unsigned B = TILE_PIXELS - 1 - (i - FIRST);
      assign load_en  = ctl.load;
      assign load_val = {ctl.attr, ctl.pat_hi[B], ctl.pat_lo[B]};
    end else begin : g_head
      assign load_en  = 1'b0;
      assign load_val = '0;
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign shift_in = queue[i];
    end else begin : g_mid
      assign shift_in = queue[i+1];
    end
    pbfr_queue_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept && ctl.shift),
      .load_en  (load_en),
      .load_val (load_val),
      .shift_in (shift_in),
      .q        (queue[i])
    );
  end

  assign entry = queue[QW'(fine_x_r)];

  always_comb begin
    out_data_nxt                = '0;
    out_data_nxt.read_request   = ctl.req;
    out_data_nxt.read_address   = ctl.addr;
    if (ctl.visible) begin
      out_data_nxt.pixel_visible  = 1'b1;
      out_data_nxt.color_index    = entry[1:0];
      out_data_nxt.palette_select = (entry[1:0] != 2'd0) ? entry[3:2] : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fine_x_r    <= '0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && (cfg_index == CFG_FINE_X)) begin
        fine_x_r <= cfg_data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_visible_dot: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_data.prerender_line && (in_data.dot_index >= 9'd1)
      && (in_data.dot_index <= 9'd256) |=> out_valid_r && out_data_r.pixel_visible)
    else $error("visible dot gave no pixel");

  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.color_index == 2'd0) |-> out_data_r.palette_select == 2'd0)
    else $error("palette on transparent pixel");

  a_no_request_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.read_request |-> out_data_r.read_address == 14'd0)
    else $error("address without request");
`endif

endmodule
